// ===== hw/rtl/radar_polar_scan_converter_macros.svh =====
// Assertion macros for the radar polar scan converter.
// Included by every RTL file that carries concurrent assertions.
`ifndef RADAR_POLAR_SCAN_CONVERTER_MACROS_SVH
`define RADAR_POLAR_SCAN_CONVERTER_MACROS_SVH
`ifndef ASSERT_OFF
`define RPSC_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rpsc assertion failed");
`define RPSC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rpsc assertion failed");
`else
`define RPSC_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define RPSC_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/rpsc_pkg.sv =====
// Shared types, constants, palettes and sine table of the scan converter.
// No dependencies.
package rpsc_pkg;

    localparam int IMAGE_SIZE_DEFAULT = 1024;
    localparam int BIN_LIMIT = 2048;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW = $clog2(QUEUE_DEPTH);
    localparam int RANGE_RESET = 1840;

    localparam logic [1:0] PAL_REFL = 2'd0;
    localparam logic [1:0] PAL_HYDRO = 2'd1;
    localparam logic [1:0] PAL_VEL = 2'd2;

    localparam logic REG_PALETTE_MODE = 1'b0;
    localparam logic REG_MAX_RANGE = 1'b1;

    localparam logic OP_DRAW = 1'b0;

    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_DRAW,
        KIND_READ
    } rpsc_kind_t;

    typedef struct packed {
        rpsc_kind_t         kind;
        logic [2:0]         sub_last;
        logic [31:0]        colour;
        logic [7:0]         value;
        logic signed [12:0] start;
        logic [11:0]        width;
        logic [11:0]        range;
        logic [9:0]         read_x;
        logic [9:0]         read_y;
    } rpsc_entry_t;

    typedef enum logic [4:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_DIVW,
        BS_ANGLE,
        BS_WRAP,
        BS_SIN1,
        BS_SIN2,
        BS_SIN3,
        BS_MULN,
        BS_MULM,
        BS_RANGE,
        BS_DIVP,
        BS_RMW_RD,
        BS_RMW_WR,
        BS_NEXT,
        BS_RD_PIX,
        BS_RD_DATA,
        BS_OUT
    } back_state_t;

    function automatic logic [91*16-1:0] build_sin_rom();
        logic [91*16-1:0] rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint s;
        rom = '0;
        for (int k = 0; k <= 90; k++) begin
            x = (64'(k) * 64'd3373259426) / 64'd180;
            x2 = (x * x) >> 30;
            t = x;
            s = longint'(x);
            for (int n = 1; n <= 6; n++) begin
                t = (t * x2) >> 30;
                case (n)
                    1: t = t / 64'd6;
                    2: t = t / 64'd20;
                    3: t = t / 64'd42;
                    4: t = t / 64'd72;
                    5: t = t / 64'd110;
                    default: t = t / 64'd156;
                endcase
                if ((n % 2) == 1) begin
                    s = s - longint'(t);
                end else begin
                    s = s + longint'(t);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            s = (s + 16384) >>> 15;
            if (s > 32767) begin
                s = 32767;
            end
            rom[k*16 +: 16] = 16'(s);
        end
        return rom;
    endfunction

    localparam logic [91*16-1:0] SIN_ROM_BITS = build_sin_rom();

    function automatic logic [15:0] sin_rom_entry(input logic [6:0] idx);
        return SIN_ROM_BITS[32'(idx)*16 +: 16];
    endfunction

    function automatic logic [31:0] rgba(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [7:0] a);
        return {a, b, g, r};
    endfunction

    function automatic logic [31:0] refl_colour(input logic [3:0] i);
        case (i)
            4'd0: return rgba(8'd4, 8'd233, 8'd231, 8'd180);
            4'd1: return rgba(8'd1, 8'd159, 8'd244, 8'd190);
            4'd2: return rgba(8'd3, 8'd0, 8'd244, 8'd200);
            4'd3: return rgba(8'd2, 8'd253, 8'd2, 8'd210);
            4'd4: return rgba(8'd1, 8'd192, 8'd1, 8'd210);
            4'd5: return rgba(8'd52, 8'd125, 8'd0, 8'd215);
            4'd6: return rgba(8'd253, 8'd191, 8'd1, 8'd220);
            4'd7: return rgba(8'd253, 8'd116, 8'd0, 8'd225);
            4'd8: return rgba(8'd253, 8'd0, 8'd0, 8'd230);
            4'd9: return rgba(8'd188, 8'd0, 8'd0, 8'd235);
            4'd10: return rgba(8'd148, 8'd0, 8'd211, 8'd240);
            4'd11: return rgba(8'd253, 8'd144, 8'd253, 8'd245);
            default: return rgba(8'd255, 8'd255, 8'd255, 8'd255);
        endcase
    endfunction

    function automatic logic [31:0] hydro_colour(input logic [3:0] c);
        case (c)
            4'd2: return rgba(8'd99, 8'd207, 8'd0, 8'd180);
            4'd3: return rgba(8'd255, 8'd165, 8'd0, 8'd180);
            4'd4: return rgba(8'd150, 8'd200, 8'd255, 8'd180);
            4'd5: return rgba(8'd0, 8'd200, 8'd255, 8'd200);
            4'd6: return rgba(8'd0, 8'd100, 8'd255, 8'd200);
            4'd7: return rgba(8'd2, 8'd253, 8'd2, 8'd200);
            4'd8: return rgba(8'd253, 8'd191, 8'd1, 8'd210);
            4'd9: return rgba(8'd253, 8'd0, 8'd0, 8'd220);
            4'd10: return rgba(8'd253, 8'd144, 8'd253, 8'd230);
            4'd11: return rgba(8'd255, 8'd255, 8'd255, 8'd240);
            4'd14: return rgba(8'd100, 8'd100, 8'd100, 8'd150);
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [7:0] vel_edge(input logic [2:0] k);
        case (k)
            3'd0: return 8'd69;
            3'd1: return 8'd89;
            3'd2: return 8'd109;
            3'd3: return 8'd125;
            3'd4: return 8'd133;
            3'd5: return 8'd149;
            3'd6: return 8'd169;
            default: return 8'd189;
        endcase
    endfunction

    function automatic logic [31:0] vel_colour(input logic [3:0] i);
        case (i)
            4'd0: return rgba(8'd0, 8'd0, 8'd180, 8'd220);
            4'd1: return rgba(8'd0, 8'd70, 8'd255, 8'd220);
            4'd2: return rgba(8'd0, 8'd180, 8'd255, 8'd210);
            4'd3: return rgba(8'd100, 8'd220, 8'd255, 8'd200);
            4'd5: return rgba(8'd255, 8'd220, 8'd100, 8'd200);
            4'd6: return rgba(8'd255, 8'd150, 8'd0, 8'd210);
            4'd7: return rgba(8'd255, 8'd50, 8'd0, 8'd220);
            4'd8: return rgba(8'd180, 8'd0, 8'd0, 8'd230);
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] pick_colour(input logic [1:0] mode, input logic [7:0] v);
        logic [3:0] i;
        i = 4'd0;
        if (v <= 8'd1) begin
            return 32'd0;
        end
        case (mode)
            PAL_HYDRO: begin
                for (int k = 1; k <= 15; k++) begin
                    if (v >= 8'(10 * k)) begin
                        i = 4'(k);
                    end
                end
                return hydro_colour(i);
            end
            PAL_VEL: begin
                for (int k = 0; k < 8; k++) begin
                    i = i + 4'(v >= vel_edge(3'(k)));
                end
                return vel_colour(i);
            end
            default: begin
                if (v < 8'd74) begin
                    return 32'd0;
                end
                for (int k = 1; k <= 12; k++) begin
                    if (v >= 8'(74 + 10 * k)) begin
                        i = 4'(k);
                    end
                end
                return refl_colour(i);
            end
        endcase
    endfunction

endpackage

// ===== hw/rtl/radar_polar_scan_converter.sv =====
// Top level of the radar polar-to-raster scan converter.
// Depends on rpsc_pkg, rpsc_front, rpsc_queue and rpsc_back.
//
// The s_ channel takes one word per item: a draw of one range bin or a read of
// one stored pixel. The m_ channel returns exactly one word per item, in order.
// The cfg_ channel writes the palette mode (index 0) or the display radius
// (index 1) and is always ready; write it only while no item is in flight.
// After reset the frame store is cleared one pixel per cycle, all of its
// IMAGE_SIZE*IMAGE_SIZE pixels (1048576 at the default size); s_ready stays
// low until then. A draw is handled by the sequencer that visits the 2 to 8
// sub-azimuths in turn through one shared sine unit, a bit-serial pixel
// divider and a read-modify-write of the frame store. A four-word queue lets
// new items be taken while the back end works and while a result waits; a
// stalled receiver fills it and then s_ready drops.
module radar_polar_scan_converter #(
    parameter int IMAGE_SIZE = rpsc_pkg::IMAGE_SIZE_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic signed [12:0] s_start_azimuth,
    input  logic [11:0]        s_azimuth_width,
    input  logic [10:0]        s_bin_index,
    input  logic [7:0]         s_bin_value,
    input  logic [9:0]         s_read_x,
    input  logic [9:0]         s_read_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_pixels_written,
    output logic [7:0]         m_red,
    output logic [7:0]         m_green,
    output logic [7:0]         m_blue,
    output logic [7:0]         m_alpha,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [13:0]        cfg_data
);
    import rpsc_pkg::*;

    rpsc_entry_t push_entry, head_entry;
    logic        q_push, q_pop, q_full, q_empty;
    logic        clear_done;
    logic [13:0] max_range;

    rpsc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_start_azimuth(s_start_azimuth),
        .s_azimuth_width(s_azimuth_width),
        .s_bin_index    (s_bin_index),
        .s_bin_value    (s_bin_value),
        .s_read_x       (s_read_x),
        .s_read_y       (s_read_y),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .clear_done     (clear_done),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (push_entry),
        .max_range      (max_range)
    );

    rpsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .entry_in (push_entry),
        .full     (q_full),
        .pop      (q_pop),
        .entry_out(head_entry),
        .empty    (q_empty)
    );

    rpsc_back #(
        .IMAGE_SIZE(IMAGE_SIZE)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_entry         (head_entry),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .max_range       (max_range),
        .clear_done      (clear_done),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixels_written(m_pixels_written),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_alpha         (m_alpha)
    );
endmodule

// ===== hw/rtl/rpsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/rpsc_front.sv =====
// Front end: configuration registers, palette lookup and item classification.
// Depends on rpsc_pkg.
module rpsc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic signed [12:0]   s_start_azimuth,
    input  logic [11:0]          s_azimuth_width,
    input  logic [10:0]          s_bin_index,
    input  logic [7:0]           s_bin_value,
    input  logic [9:0]           s_read_x,
    input  logic [9:0]           s_read_y,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [13:0]          cfg_data,
    input  logic                 clear_done,
    input  logic                 q_full,
    output logic                 q_push,
    output rpsc_pkg::rpsc_entry_t q_entry,
    output logic [13:0]          max_range
);
    import rpsc_pkg::*;

    logic [1:0]  palette_mode_reg;
    logic [13:0] max_range_reg;
    logic [31:0] colour;
    logic [11:0] range;
    logic        skip;
    logic [2:0]  sub_last;

    assign cfg_ready = 1'b1;
    assign max_range = max_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_mode_reg <= PAL_REFL;
            max_range_reg <= 14'(RANGE_RESET);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PALETTE_MODE: palette_mode_reg <= cfg_data[1:0];
                REG_MAX_RANGE: max_range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        colour = pick_colour(palette_mode_reg, s_bin_value);
        range = {s_bin_index, 1'b1};
        skip = (s_bin_value <= 8'd1) || (colour[31:24] == 8'd0) ||
               (13'(s_bin_index) >= 13'(BIN_LIMIT)) || (max_range_reg == 14'd0) ||
               (14'(range) > max_range_reg);
        sub_last = 3'd1 + 3'(s_azimuth_width >= 12'd3) + 3'(s_azimuth_width >= 12'd5) +
                   3'(s_azimuth_width >= 12'd8) + 3'(s_azimuth_width >= 12'd10) +
                   3'(s_azimuth_width >= 12'd13) + 3'(s_azimuth_width >= 12'd15);
    end

    assign s_ready = clear_done && !q_full;
    assign q_push = s_valid && s_ready;

    always_comb begin
        q_entry.kind = (s_operation != OP_DRAW) ? KIND_READ : (skip ? KIND_SKIP : KIND_DRAW);
        q_entry.sub_last = sub_last;
        q_entry.colour = colour;
        q_entry.value = s_bin_value;
        q_entry.start = s_start_azimuth;
        q_entry.width = s_azimuth_width;
        q_entry.range = range;
        q_entry.read_x = s_read_x;
        q_entry.read_y = s_read_y;
    end
endmodule

// ===== hw/rtl/rpsc_queue.sv =====
// Short queue of classified items between the front and back ends.
// Depends on rpsc_pkg.
module rpsc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  rpsc_pkg::rpsc_entry_t entry_in,
    output logic                  full,
    input  logic                  pop,
    output rpsc_pkg::rpsc_entry_t entry_out,
    output logic                  empty
);
    import rpsc_pkg::*;

    rpsc_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]  wr_ptr_reg;
    logic [QUEUE_PW-1:0]  rd_ptr_reg;
    logic [QUEUE_PW:0]    count_reg;

    assign full = (count_reg == (QUEUE_PW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign entry_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QUEUE_PW+1)'(push) - (QUEUE_PW+1)'(pop);
        end
    end
endmodule

// ===== hw/rtl/rpsc_back.sv =====
// Back end: sub-azimuth sequencer, sine unit, pixel divider and frame store.
// Depends on rpsc_pkg, rpsc_ram and the assertion macro header.
`include "radar_polar_scan_converter_macros.svh"
module rpsc_back #(
    parameter int IMAGE_SIZE = rpsc_pkg::IMAGE_SIZE_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rpsc_pkg::rpsc_entry_t q_entry,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic [13:0]           max_range,
    output logic                  clear_done,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_pixels_written,
    output logic [7:0]            m_red,
    output logic [7:0]            m_green,
    output logic [7:0]            m_blue,
    output logic [7:0]            m_alpha
);
    import rpsc_pkg::*;

    localparam int QW = $clog2(IMAGE_SIZE);
    localparam int DEPTH = IMAGE_SIZE * IMAGE_SIZE;
    localparam int AW = $clog2(DEPTH);
    localparam int NUMW = 30 + QW;

    back_state_t        state_reg, state_next;
    rpsc_entry_t        ent_reg;
    logic [15:0]        wq_reg;
    logic [2:0]         drem_reg;
    logic [15:0]        off_reg;
    logic [2:0]         arem_reg;
    logic [2:0]         s_reg;
    logic [4:0]         step_reg;
    logic [17:0]        ang_reg;
    logic               cos_phase_reg;
    logic [6:0]         idx_reg;
    logic [7:0]         frac_reg;
    logic               neg_reg;
    logic [15:0]        s0_reg;
    logic [23:0]        prod_reg;
    logic signed [16:0] sn_reg, cs_reg;
    logic signed [31:0] n_reg, m_reg;
    logic [NUMW-1:0]    numx_reg, numy_reg, dsh_reg;
    logic [QW-1:0]      px_reg, py_reg;
    logic [3:0]         wr_cnt_reg;
    logic [31:0]        pix_col_reg;
    logic               inside_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               m_valid_reg;
    logic [3:0]         m_pix_reg;
    logic [31:0]        m_col_reg;

    logic [3:0]         d4, rem_t, rsum;
    logic               div_ge, carry;
    logic [2:0]         drem_n, arem_n;
    logic [15:0]        off_n;
    logic signed [18:0] a_sum;
    logic [17:0]        ang_cos;
    logic [1:0]         quad;
    logic [13:0]        rr, rq;
    logic [21:0]        idx_mul;
    logic [6:0]         idx_w;
    logic [7:0]         frac_w;
    logic [6:0]         idx_up;
    logic [15:0]        s1_w;
    logic [31:0]        qd_mul;
    logic [16:0]        sin_mag;
    logic signed [16:0] sval;
    logic signed [12:0] rng_s;
    logic signed [29:0] prod_n, prod_m;
    logic signed [31:0] r15_s, span_s;
    logic               in_range;
    logic               gx, gy;
    logic [AW-1:0]      pix_addr, rd_addr;
    logic               read_inside;
    logic [31:0]        rdata;
    logic               upd;
    logic               out_free;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [31:0]        ram_wdata;

    always_comb begin
        d4 = {1'b0, ent_reg.sub_last};
        rem_t = {drem_reg, wq_reg[15]};
        div_ge = rem_t >= d4;
        drem_n = 3'(div_ge ? rem_t - d4 : rem_t);
        rsum = {1'b0, arem_reg} + {1'b0, drem_reg};
        carry = rsum >= d4;
        arem_n = 3'(carry ? rsum - d4 : rsum);
        off_n = off_reg + wq_reg + 16'(carry);
        a_sum = $signed({{2{ent_reg.start[12]}}, ent_reg.start, 4'b0}) +
                $signed({3'b0, off_reg}) + 19'sd115200;
        ang_cos = (ang_reg + 18'd14400 >= 18'd57600) ? ang_reg + 18'd14400 - 18'd57600
                                                    : ang_reg + 18'd14400;
    end

    always_comb begin
        if (ang_reg < 18'd14400) begin
            quad = 2'd0;
            rr = 14'(ang_reg);
        end else if (ang_reg < 18'd28800) begin
            quad = 2'd1;
            rr = 14'(ang_reg - 18'd14400);
        end else if (ang_reg < 18'd43200) begin
            quad = 2'd2;
            rr = 14'(ang_reg - 18'd28800);
        end else begin
            quad = 2'd3;
            rr = 14'(ang_reg - 18'd43200);
        end
        rq = quad[0] ? 14'd14400 - rr : rr;
        idx_mul = 22'(rq[13:5]) * 22'd6554;
        idx_w = 7'(idx_mul >> 15);
        frac_w = 8'(rq - 14'(16'(idx_w) * 16'd160));
        idx_up = (idx_reg == 7'd90) ? idx_reg : idx_reg + 7'd1;
        s1_w = sin_rom_entry(idx_up);
        qd_mul = 32'(prod_reg[23:5]) * 32'd6554;
        sin_mag = {1'b0, s0_reg} + 17'(qd_mul >> 15);
        sval = neg_reg ? -$signed(sin_mag) : $signed(sin_mag);
    end

    always_comb begin
        rng_s = $signed({1'b0, ent_reg.range});
        prod_n = rng_s * sn_reg;
        prod_m = rng_s * cs_reg;
        r15_s = $signed({3'b0, max_range, 15'b0});
        span_s = $signed({2'b0, max_range, 16'b0});
        in_range = (n_reg >= 0) && (n_reg < span_s) && (m_reg >= 0) && (m_reg < span_s);
        gx = numx_reg >= dsh_reg;
        gy = numy_reg >= dsh_reg;
        pix_addr = AW'(32'(py_reg) * IMAGE_SIZE + 32'(px_reg));
        rd_addr = AW'(32'(ent_reg.read_y) * IMAGE_SIZE + 32'(ent_reg.read_x));
        read_inside = (32'(ent_reg.read_x) < IMAGE_SIZE) && (32'(ent_reg.read_y) < IMAGE_SIZE);
        upd = (rdata[31:24] == 8'd0) || (ent_reg.value > rdata[31:24]);
        out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BS_CLEAR: if (clr_addr_reg == AW'(DEPTH - 1)) state_next = BS_IDLE;
            BS_IDLE: begin
                if (!q_empty) begin
                    case (q_entry.kind)
                        KIND_DRAW: state_next = BS_DIVW;
                        KIND_READ: state_next = BS_RD_PIX;
                        default: state_next = BS_OUT;
                    endcase
                end
            end
            BS_DIVW: if (step_reg == 5'd1) state_next = BS_ANGLE;
            BS_ANGLE: state_next = BS_WRAP;
            BS_WRAP: if (ang_reg < 18'd57600) state_next = BS_SIN1;
            BS_SIN1: state_next = BS_SIN2;
            BS_SIN2: state_next = BS_SIN3;
            BS_SIN3: state_next = cos_phase_reg ? BS_MULN : BS_SIN1;
            BS_MULN: state_next = BS_MULM;
            BS_MULM: state_next = BS_RANGE;
            BS_RANGE: state_next = in_range ? BS_DIVP : BS_NEXT;
            BS_DIVP: if (step_reg == 5'd1) state_next = BS_RMW_RD;
            BS_RMW_RD: state_next = BS_RMW_WR;
            BS_RMW_WR: state_next = BS_NEXT;
            BS_NEXT: state_next = (s_reg == ent_reg.sub_last) ? BS_OUT : BS_ANGLE;
            BS_RD_PIX: state_next = BS_RD_DATA;
            BS_RD_DATA: state_next = BS_OUT;
            BS_OUT: if (out_free) state_next = BS_IDLE;
            default: state_next = BS_IDLE;
        endcase
    end

    always_comb begin
        q_pop = (state_reg == BS_IDLE) && !q_empty;
        clear_done = (state_reg != BS_CLEAR);
        ram_we = 1'b0;
        ram_waddr = pix_addr;
        ram_wdata = ent_reg.colour;
        ram_raddr = pix_addr;
        case (state_reg)
            BS_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = 32'd0;
            end
            BS_RMW_WR: ram_we = upd;
            BS_RD_PIX: ram_raddr = rd_addr;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BS_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                BS_CLEAR: clr_addr_reg <= clr_addr_reg + 1'b1;
                BS_IDLE: begin
                    ent_reg <= q_entry;
                    wq_reg <= {q_entry.width, 4'b0};
                    drem_reg <= 3'd0;
                    step_reg <= 5'd16;
                    s_reg <= 3'd0;
                    off_reg <= 16'd0;
                    arem_reg <= 3'd0;
                    wr_cnt_reg <= 4'd0;
                end
                BS_DIVW: begin
                    wq_reg <= {wq_reg[14:0], div_ge};
                    drem_reg <= drem_n;
                    step_reg <= step_reg - 5'd1;
                end
                BS_ANGLE: begin
                    ang_reg <= 18'(a_sum);
                    cos_phase_reg <= 1'b0;
                end
                BS_WRAP: if (ang_reg >= 18'd57600) ang_reg <= ang_reg - 18'd57600;
                BS_SIN1: begin
                    idx_reg <= idx_w;
                    frac_reg <= frac_w;
                    neg_reg <= quad[1];
                end
                BS_SIN2: begin
                    s0_reg <= sin_rom_entry(idx_reg);
                    prod_reg <= 24'(s1_w - sin_rom_entry(idx_reg)) * {16'b0, frac_reg};
                end
                BS_SIN3: begin
                    if (cos_phase_reg) begin
                        cs_reg <= sval;
                    end else begin
                        sn_reg <= sval;
                        ang_reg <= ang_cos;
                        cos_phase_reg <= 1'b1;
                    end
                end
                BS_MULN: n_reg <= 32'(prod_n) + r15_s;
                BS_MULM: m_reg <= r15_s - 32'(prod_m);
                BS_RANGE: begin
                    numx_reg <= NUMW'(n_reg[29:0]) * NUMW'(IMAGE_SIZE);
                    numy_reg <= NUMW'(m_reg[29:0]) * NUMW'(IMAGE_SIZE);
                    dsh_reg <= NUMW'({max_range, 16'b0}) << (QW - 1);
                    px_reg <= '0;
                    py_reg <= '0;
                    step_reg <= 5'(QW);
                end
                BS_DIVP: begin
                    if (gx) numx_reg <= numx_reg - dsh_reg;
                    if (gy) numy_reg <= numy_reg - dsh_reg;
                    px_reg <= QW'({px_reg, gx});
                    py_reg <= QW'({py_reg, gy});
                    dsh_reg <= dsh_reg >> 1;
                    step_reg <= step_reg - 5'd1;
                end
                BS_RMW_WR: if (upd) wr_cnt_reg <= wr_cnt_reg + 4'd1;
                BS_NEXT: begin
                    s_reg <= s_reg + 3'd1;
                    off_reg <= off_n;
                    arem_reg <= arem_n;
                end
                BS_RD_PIX: inside_reg <= read_inside;
                BS_RD_DATA: pix_col_reg <= inside_reg ? rdata : 32'd0;
                BS_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_pix_reg <= (ent_reg.kind == KIND_DRAW) ? wr_cnt_reg : 4'd0;
                        m_col_reg <= (ent_reg.kind == KIND_READ) ? pix_col_reg : 32'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    rpsc_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_frame (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_pixels_written = m_pix_reg;
    assign m_red = m_col_reg[7:0];
    assign m_green = m_col_reg[15:8];
    assign m_blue = m_col_reg[23:16];
    assign m_alpha = m_col_reg[31:24];

    `RPSC_ASSERT_IMPL(a_clear_quiet, aclk, aresetn, state_reg == BS_CLEAR, !m_valid_reg)
    `RPSC_ASSERT_NEXT(a_rmw_pair, aclk, aresetn, state_reg == BS_RMW_RD, state_reg == BS_RMW_WR)
    `RPSC_ASSERT_IMPL(a_sub_bound, aclk, aresetn, state_reg == BS_NEXT, s_reg <= ent_reg.sub_last)
    `RPSC_ASSERT_IMPL(a_count_bound, aclk, aresetn, state_reg == BS_OUT, wr_cnt_reg <= 4'd8)
endmodule

// ===== test/radar_polar_scan_converter_tb.sv =====
// Self-checking testbench for radar_polar_scan_converter: draws range bins and
// reads pixels back, checking every result word against a behavioral model or a
// fixed expected word. Depends on rpsc_pkg and the radar_polar_scan_converter RTL.
module radar_polar_scan_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpsc_pkg::*;

    localparam int IMG = 1024;
    localparam int QTR = 14400;
    localparam int TURN = 57600;
    localparam logic OP_READ = ~OP_DRAW;
    localparam logic [1:0] PAL_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic               op;
        logic signed [12:0] start;
        logic [11:0]        width;
        logic [10:0]        bin;
        logic [7:0]         val;
        logic [9:0]         rx;
        logic [9:0]         ry;
    } bin_word_t;

    typedef struct {
        logic [3:0]  count;
        logic [31:0] rgba;
    } pixel_word_t;

    typedef struct {
        bin_word_t   w;
        bit          known;
        pixel_word_t res;
    } stim_row_t;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_operation = 0;
    logic signed [12:0] s_start_azimuth = 0;
    logic [11:0]        s_azimuth_width = 0;
    logic [10:0]        s_bin_index = 0;
    logic [7:0]         s_bin_value = 0;
    logic [9:0]         s_read_x = 0;
    logic [9:0]         s_read_y = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [3:0]         m_pixels_written;
    logic [7:0]         m_red;
    logic [7:0]         m_green;
    logic [7:0]         m_blue;
    logic [7:0]         m_alpha;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic               cfg_index = 0;
    logic [13:0]        cfg_data = 0;

    radar_polar_scan_converter DUT (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    int          sine_tab[91];
    logic [31:0] pixel_mem[int];
    logic [1:0]  pal_mode = PAL_REFL;
    int          radius = RANGE_RESET;
    int          touched_x[$];
    int          touched_y[$];
    pixel_word_t pending_pixels[$];
    bin_word_t   sent_bins[$];
    int          errors = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    bit          hold_start = 0;
    int          cycles = 0;

    logic [31:0] refl_pal[13] = '{
        32'hB4E7E904, 32'hBEF49F01, 32'hC8F40003, 32'hD202FD02, 32'hD201C001,
        32'hD7007D34, 32'hDC01BFFD, 32'hE10074FD, 32'hE60000FD, 32'hEB0000BC,
        32'hF0D30094, 32'hF5FD90FD, 32'hFFFFFFFF};
    logic [31:0] hydro_pal[16] = '{
        32'h0, 32'h0, 32'hB400CF63, 32'hB400A5FF, 32'hB4FFC896, 32'hC8FFC800,
        32'hC8FF6400, 32'hC802FD02, 32'hD201BFFD, 32'hDC0000FD, 32'hE6FD90FD,
        32'hF0FFFFFF, 32'h0, 32'h0, 32'h96646464, 32'h0};
    int          vel_bounds[8] = '{69, 89, 109, 125, 133, 149, 169, 189};
    logic [31:0] vel_pal[9] = '{
        32'hDCB40000, 32'hDCFF4600, 32'hD2FFB400, 32'hC8FFDC64, 32'h0,
        32'hC864DCFF, 32'hD20096FF, 32'hDC0032FF, 32'hE60000B4};

    function automatic void make_sine_table();
        longint unsigned x, x2, t;
        longint s;
        for (int k = 0; k <= 90; k++) begin
            x = longint'(k) * 64'd3373259426 / 64'd180;
            x2 = (x * x) >> 30;
            t = x;
            s = longint'(x);
            for (int n = 1; n <= 6; n++) begin
                t = (t * x2) >> 30;
                t = t / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) s -= longint'(t);
                else s += longint'(t);
            end
            if (s < 0) s = 0;
            s = (s + 16384) >>> 15;
            if (s > 32767) s = 32767;
            sine_tab[k] = int'(s);
        end
    endfunction

    function automatic int first_quadrant_sine(int r);
        int idx, frac;
        if (r >= QTR) return sine_tab[90];
        idx = r / 160;
        frac = r % 160;
        return sine_tab[idx] + (sine_tab[idx + 1] - sine_tab[idx]) * frac / 160;
    endfunction

    function automatic int sine_q15(int a);
        case (a / QTR)
            0: return first_quadrant_sine(a % QTR);
            1: return first_quadrant_sine(QTR - a % QTR);
            2: return -first_quadrant_sine(a % QTR);
            default: return -first_quadrant_sine(QTR - a % QTR);
        endcase
    endfunction

    function automatic logic [31:0] palette_colour(int v);
        int i;
        if (v <= 1) return 32'h0;
        if (pal_mode == PAL_HYDRO) return hydro_pal[(v / 10 > 15) ? 15 : v / 10];
        if (pal_mode == PAL_VEL) begin
            i = 0;
            while (i < 8 && v >= vel_bounds[i]) i++;
            return vel_pal[i];
        end
        if (v < 74) return 32'h0;
        i = (v - 74) / 10;
        return refl_pal[(i > 12) ? 12 : i];
    endfunction

    function automatic pixel_word_t convert_bin(bin_word_t w);
        pixel_word_t r;
        logic [31:0] col;
        int rng, nsub, a, sn, cs, px, py, v, idx;
        longint r15, span, n, m;
        r.count = 0;
        r.rgba = 0;
        if (w.op == OP_READ) begin
            idx = int'(w.ry) * IMG + int'(w.rx);
            if (pixel_mem.exists(idx)) r.rgba = pixel_mem[idx];
            return r;
        end
        v = w.val;
        col = palette_colour(v);
        rng = 2 * int'(w.bin) + 1;
        if (v <= 1 || col[31:24] == 0 || radius == 0 || rng > radius) return r;
        nsub = 2 * int'(w.width) / 5 + 2;
        if (nsub > 8) nsub = 8;
        r15 = longint'(radius) * 32768;
        span = 2 * r15;
        for (int s = 0; s < nsub; s++) begin
            a = int'(w.start) * 16 + (16 * int'(w.width) * s) / (nsub - 1);
            a = a % TURN;
            if (a < 0) a += TURN;
            sn = sine_q15(a);
            cs = sine_q15((a + QTR) % TURN);
            n = longint'(rng) * sn + r15;
            m = r15 - longint'(rng) * cs;
            if (n < 0 || n >= span || m < 0 || m >= span) continue;
            px = int'(n * IMG / span);
            py = int'(m * IMG / span);
            idx = py * IMG + px;
            if (!pixel_mem.exists(idx) || pixel_mem[idx][31:24] == 0 ||
                    v > pixel_mem[idx][31:24]) begin
                pixel_mem[idx] = col;
                r.count++;
                touched_x.push_back(px);
                touched_y.push_back(py);
                if (touched_x.size() > 256) begin
                    void'(touched_x.pop_front());
                    void'(touched_y.pop_front());
                end
            end
        end
        return r;
    endfunction

    // Per-item flags and fixed expected results, queued as items are sent and popped as each input is accepted.
    bit          row_known[$];
    pixel_word_t row_result[$];

    always @(posedge aclk) begin
        pixel_word_t p, got;
        bin_word_t   w;
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready) begin
            w = '{s_operation, s_start_azimuth, s_azimuth_width, s_bin_index,
                  s_bin_value, s_read_x, s_read_y};
            p = convert_bin(w);
            if (row_known.size() > 0) begin
                if (row_known.pop_front()) p = row_result.pop_front();
                else void'(row_result.pop_front());
            end
            pending_pixels.push_back(p);
        end
        if (aresetn && m_valid && m_ready) begin
            got.count = m_pixels_written;
            got.rgba = {m_alpha, m_blue, m_green, m_red};
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%t: unexpected result word count=%0d rgba=%h", $realtime,
                         got.count, got.rgba);
            end else begin
                p = pending_pixels.pop_front();
                if (got.count !== p.count) begin
                    errors++;
                    $display("%t: pixels_written expected %0d actual %0d", $realtime,
                             p.count, got.count);
                end
                if (got.rgba[7:0] !== p.rgba[7:0]) begin
                    errors++;
                    $display("%t: red expected %0d actual %0d", $realtime,
                             p.rgba[7:0], got.rgba[7:0]);
                end
                if (got.rgba[15:8] !== p.rgba[15:8]) begin
                    errors++;
                    $display("%t: green expected %0d actual %0d", $realtime,
                             p.rgba[15:8], got.rgba[15:8]);
                end
                if (got.rgba[23:16] !== p.rgba[23:16]) begin
                    errors++;
                    $display("%t: blue expected %0d actual %0d", $realtime,
                             p.rgba[23:16], got.rgba[23:16]);
                end
                if (got.rgba[31:24] !== p.rgba[31:24]) begin
                    errors++;
                    $display("%t: alpha expected %0d actual %0d", $realtime,
                             p.rgba[31:24], got.rgba[31:24]);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_start) begin
            hold_start = 0;
            hold_left <= HOLD_CYCLES;
            m_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 0;
        end else if (!aresetn) begin
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_bin(bin_word_t w);
        if (send_gap_pct > 0) begin
            if ($urandom_range(99) < send_gap_pct) begin
                s_valid <= 0;
                do @(posedge aclk); while ($urandom_range(99) < send_gap_pct);
            end
        end
        s_valid <= 1;
        s_operation <= w.op;
        s_start_azimuth <= w.start;
        s_azimuth_width <= w.width;
        s_bin_index <= w.bin;
        s_bin_value <= w.val;
        s_read_x <= w.rx;
        s_read_y <= w.ry;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        if (s_valid) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        while (pending_pixels.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [13:0] data);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == REG_PALETTE_MODE) pal_mode = data[1:0];
        else radius = data;
    endtask

    function automatic bin_word_t random_bin();
        bin_word_t w;
        int top;
        w.op = ($urandom_range(99) < 35) ? OP_READ : OP_DRAW;
        w.rx = $urandom;
        w.ry = $urandom;
        if (w.op == OP_READ && touched_x.size() > 0 && $urandom_range(1)) begin
            top = $urandom_range(touched_x.size() - 1);
            w.rx = touched_x[top];
            w.ry = touched_y[top];
        end
        w.start = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(7200) - 3600);
        w.width = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(25));
        top = (radius > 1) ? (radius - 1) / 2 : 0;
        if (top > 2047) top = 2047;
        w.bin = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(top));
        w.val = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(255, 60));
        return w;
    endfunction

    task automatic random_phase(int count, logic [1:0] mode, logic [13:0] rng,
                                int gap, int stall);
        write_reg(REG_PALETTE_MODE, 14'(mode));
        write_reg(REG_MAX_RANGE, rng);
        send_gap_pct = gap;
        stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            row_known.push_back(0);
            row_result.push_back('{0, 0});
            send_bin(random_bin());
        end
    endtask

    stim_row_t directed[$] = '{
        '{'{OP_READ, 0, 0, 0, 0, 0, 0}, 1, '{0, 0}},
        '{'{OP_READ, 0, 0, 0, 0, 1023, 1023}, 1, '{0, 0}},
        '{'{OP_DRAW, 0, 0, 0, 0, 0, 0}, 1, '{0, 0}},
        '{'{OP_DRAW, 0, 0, 0, 1, 0, 0}, 1, '{0, 0}},
        '{'{OP_DRAW, 0, 0, 0, 73, 0, 0}, 1, '{0, 0}},
        '{'{OP_DRAW, 0, 0, 2047, 255, 0, 0}, 1, '{0, 0}},
        '{'{OP_DRAW, 0, 0, 920, 200, 0, 0}, 1, '{0, 0}},
        '{'{OP_DRAW, 0, 0, 0, 255, 0, 0}, 0, '{0, 0}},
        '{'{OP_READ, 0, 0, 0, 0, 512, 511}, 0, '{0, 0}},
        '{'{OP_DRAW, 0, 0, 0, 80, 0, 0}, 0, '{0, 0}},
        '{'{OP_READ, 0, 0, 0, 0, 512, 511}, 0, '{0, 0}},
        '{'{OP_DRAW, -3600, 3600, 919, 200, 0, 0}, 0, '{0, 0}},
        '{'{OP_DRAW, 3600, 4095, 500, 100, 0, 0}, 0, '{0, 0}},
        '{'{OP_DRAW, -4096, 25, 10, 150, 0, 0}, 0, '{0, 0}},
        '{'{OP_DRAW, 4095, 1, 20, 74, 0, 0}, 0, '{0, 0}},
        '{'{OP_DRAW, 900, 2, 300, 193, 0, 0}, 0, '{0, 0}},
        '{'{OP_DRAW, 900, 2, 300, 194, 0, 0}, 0, '{0, 0}},
        '{'{OP_DRAW, -900, 5, 100, 2, 0, 0}, 0, '{0, 0}},
        '{'{OP_READ, 0, 0, 0, 0, 682, 341}, 0, '{0, 0}}
    };

    initial begin
        make_sine_table();
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        foreach (directed[i]) begin
            row_known.push_back(directed[i].known);
            row_result.push_back(directed[i].res);
            send_bin(directed[i].w);
        end
        random_phase(350, PAL_REFL, 14'd1840, 0, 0);
        random_phase(300, PAL_HYDRO, 14'd16383, 84, 0);
        random_phase(300, PAL_VEL, 14'd1, 0, 84);
        random_phase(300, PAL_SPARE, 14'd100, 10, 10);
        random_phase(40, PAL_REFL, 14'd0, 0, 0);
        random_phase(250, PAL_VEL, 14'd300, 0, 0);
        hold_start = 1;
        for (int i = 0; i < 30; i++) begin
            row_known.push_back(0);
            row_result.push_back('{0, 0});
            send_bin(random_bin());
        end
        drain();
        random_phase(450, PAL_HYDRO, 14'd1840, 30, 30);
        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
